>>> src/c8alu_pkg.sv
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types and instruction-field codes for the register ALU.
// ----------------------------------------------------------------------------
package c8alu_pkg;

    // result status
    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_ILLEGAL     = 2'd1,
        ST_NOT_HANDLED = 2'd2
    } status_t;

    // instruction groups (bits 15..12)
    localparam logic [3:0] GRP_SKIP_EQ_NN = 4'h3;
    localparam logic [3:0] GRP_SKIP_NE_NN = 4'h4;
    localparam logic [3:0] GRP_SKIP_EQ_VY = 4'h5;
    localparam logic [3:0] GRP_LOAD_NN    = 4'h6;
    localparam logic [3:0] GRP_ADD_NN     = 4'h7;
    localparam logic [3:0] GRP_ALU        = 4'h8;
    localparam logic [3:0] GRP_SKIP_NE_VY = 4'h9;
    localparam logic [3:0] GRP_LOAD_INDEX = 4'hA;
    localparam logic [3:0] GRP_MISC       = 4'hF;

    // 8xyN sub-codes
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_RSUB = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Fx1E low byte
    localparam logic [7:0] MISC_ADD_INDEX = 8'h1E;

    // flag register number
    localparam logic [3:0] REG_F = 4'hF;

    localparam int unsigned INDEX_W = 24;

endpackage

>>> src/chip8_register_alu.sv
// ----------------------------------------------------------------------------
// chip8_register_alu
// Register-only instruction executor with 16 x 8-bit V file and index reg.
// ----------------------------------------------------------------------------
// Stages: read at request acceptance, then execute into the result register
// when that register is free or being emptied.
// Throughput: one request per cycle unless out_ready stalls; the V file is read
// at accept with bypass from the same-cycle write-back, so dependent words stream.
// Reset: V0..VE read as zero through per-entry valid bits, VF and the index
// register clear at once; no clearing pass, requests taken right after reset.
module chip8_register_alu
    import c8alu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          instr,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 skip,
    output logic [7:0]           vx_after,
    output logic [7:0]           vf_after,
    output logic [INDEX_W-1:0]   index_after,
    output logic [1:0]           status
);

    // ------------------------------------------------------------------
    // Handshake: execute stage advances whenever the result register is
    // free or being emptied; input stage refills behind it.
    // ------------------------------------------------------------------
    logic        ex_valid_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        ex_go;
    logic        in_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign ex_go    = ex_valid_reg && out_free;
    assign in_ready = !ex_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Architectural state. V0..VE live in a small memory; VF is a flop so
    // that result and flag can both be written in the same cycle.
    // ------------------------------------------------------------------
    logic [7:0]          vmem [16];
    logic [15:0]         vld_reg;
    logic [7:0]          vf_reg;
    logic [INDEX_W-1:0]  idx_reg;

    // execute-stage request and captured operands
    logic [15:0] ex_instr_reg;
    logic [7:0]  raw_x_reg, raw_y_reg;
    logic        vld_x_reg, vld_y_reg;
    logic        byp_x_reg, byp_y_reg;
    logic [7:0]  byp_x_data_reg, byp_y_data_reg;

    logic [3:0]  rx_addr, ry_addr;
    assign rx_addr = instr[11:8];
    assign ry_addr = instr[7:4];

    // decoded execute fields
    logic [3:0]  grp, x_sel, n_sel;
    logic [7:0]  nn;
    logic [11:0] nnn;
    assign grp   = ex_instr_reg[15:12];
    assign x_sel = ex_instr_reg[11:8];
    assign n_sel = ex_instr_reg[3:0];
    assign nn    = ex_instr_reg[7:0];
    assign nnn   = ex_instr_reg[11:0];

    // operands after bypass and reset-valid masking
    logic [7:0] opa, opb;
    assign opa = byp_x_reg ? byp_x_data_reg : (vld_x_reg ? raw_x_reg : 8'h00);
    assign opb = byp_y_reg ? byp_y_data_reg : (vld_y_reg ? raw_y_reg : 8'h00);

    // arithmetic
    logic [8:0] sum_ab, diff_ab, diff_ba;
    assign sum_ab  = {1'b0, opa} + {1'b0, opb};
    assign diff_ab = {1'b0, opa} - {1'b0, opb};
    assign diff_ba = {1'b0, opb} - {1'b0, opa};

    // execute results
    logic               vx_we, flag_we, idx_we, skip_c;
    logic [7:0]         vx_val, flag_val, vf_res, vx_res;
    logic [INDEX_W-1:0] idx_val, idx_res;
    status_t            st_c;

    always_comb
    begin
        vx_we    = 1'b0;
        vx_val   = opa;
        flag_we  = 1'b0;
        flag_val = 8'h00;
        idx_we   = 1'b0;
        idx_val  = idx_reg;
        skip_c   = 1'b0;
        st_c     = ST_DONE;
        unique case (grp)
            GRP_SKIP_EQ_NN: skip_c = (opa == nn);
            GRP_SKIP_NE_NN: skip_c = (opa != nn);
            GRP_SKIP_EQ_VY:
            begin
                if (n_sel != 4'h0)
                    st_c = ST_ILLEGAL;
                else
                    skip_c = (opa == opb);
            end
            GRP_SKIP_NE_VY:
            begin
                if (n_sel != 4'h0)
                    st_c = ST_ILLEGAL;
                else
                    skip_c = (opa != opb);
            end
            GRP_LOAD_NN:
            begin
                vx_we  = 1'b1;
                vx_val = nn;
            end
            GRP_ADD_NN:
            begin
                vx_we  = 1'b1;
                vx_val = opa + nn;
            end
            GRP_ALU:
            begin
                unique case (n_sel)
                    ALU_MOV:  begin vx_we = 1'b1; vx_val = opb; end
                    ALU_OR:   begin vx_we = 1'b1; vx_val = opa | opb; end
                    ALU_AND:  begin vx_we = 1'b1; vx_val = opa & opb; end
                    ALU_XOR:  begin vx_we = 1'b1; vx_val = opa ^ opb; end
                    ALU_ADD:
                    begin
                        vx_we    = 1'b1;
                        vx_val   = sum_ab[7:0];
                        flag_we  = 1'b1;
                        flag_val = {7'b0, sum_ab[8]};
                    end
                    ALU_SUB:
                    begin
                        vx_we    = 1'b1;
                        vx_val   = diff_ab[7:0];
                        flag_we  = 1'b1;
                        flag_val = {7'b0, !diff_ab[8]};
                    end
                    ALU_RSUB:
                    begin
                        vx_we    = 1'b1;
                        vx_val   = diff_ba[7:0];
                        flag_we  = 1'b1;
                        flag_val = {7'b0, !diff_ba[8]};
                    end
                    ALU_SHR:
                    begin
                        vx_we    = 1'b1;
                        vx_val   = {1'b0, opa[7:1]};
                        flag_we  = 1'b1;
                        flag_val = {7'b0, opa[0]};
                    end
                    ALU_SHL:
                    begin
                        vx_we    = 1'b1;
                        vx_val   = {opa[6:0], 1'b0};
                        flag_we  = 1'b1;
                        flag_val = {7'b0, opa[7]};
                    end
                    default: st_c = ST_ILLEGAL;
                endcase
            end
            GRP_LOAD_INDEX:
            begin
                idx_we  = 1'b1;
                idx_val = {{(INDEX_W-12){1'b0}}, nnn};
            end
            GRP_MISC:
            begin
                if (nn == MISC_ADD_INDEX)
                begin
                    idx_we  = 1'b1;
                    idx_val = idx_reg + {{(INDEX_W-8){1'b0}}, opa};
                end
                else
                    st_c = ST_NOT_HANDLED;
            end
            default: st_c = ST_NOT_HANDLED;
        endcase
    end

    // flag written after the result, so it wins when X is VF
    always_comb
    begin
        priority if (flag_we)
            vf_res = flag_val;
        else if (vx_we && (x_sel == REG_F))
            vf_res = vx_val;
        else
            vf_res = vf_reg;
    end

    assign vx_res  = (x_sel == REG_F) ? vf_res : vx_val;
    assign idx_res = idx_we ? idx_val : idx_reg;

    logic mem_we;
    assign mem_we = ex_go && vx_we && (x_sel != REG_F);

    // ------------------------------------------------------------------
    // Operand bypass: a request read in the same cycle as a write-back
    // sees the value being written.
    // ------------------------------------------------------------------
    logic       byp_x_next, byp_y_next;
    logic [7:0] byp_x_data_next, byp_y_data_next;

    always_comb
    begin
        byp_x_next      = (rx_addr == REG_F) || (mem_we && (x_sel == rx_addr));
        byp_y_next      = (ry_addr == REG_F) || (mem_we && (x_sel == ry_addr));
        byp_x_data_next = (rx_addr == REG_F) ? (ex_go ? vf_res : vf_reg) : vx_val;
        byp_y_data_next = (ry_addr == REG_F) ? (ex_go ? vf_res : vf_reg) : vx_val;
    end

    // V memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            vmem[x_sel] <= vx_val;
        if (in_fire)
        begin
            raw_x_reg <= vmem[rx_addr];
            raw_y_reg <= vmem[ry_addr];
        end
    end

    // execute-stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ex_instr_reg   <= instr;
            vld_x_reg      <= vld_reg[rx_addr];
            vld_y_reg      <= vld_reg[ry_addr];
            byp_x_reg      <= byp_x_next;
            byp_y_reg      <= byp_y_next;
            byp_x_data_reg <= byp_x_data_next;
            byp_y_data_reg <= byp_y_data_next;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            vf_reg        <= 8'h00;
            idx_reg       <= '0;
        end
        else
        begin
            if (in_fire)
                ex_valid_reg <= 1'b1;
            else if (ex_go)
                ex_valid_reg <= 1'b0;

            if (ex_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (mem_we)
                vld_reg[x_sel] <= 1'b1;

            if (ex_go)
            begin
                vf_reg  <= vf_res;
                idx_reg <= idx_res;
            end
        end
    end

    // result register
    logic               skip_reg;
    logic [7:0]         vx_after_reg, vf_after_reg;
    logic [INDEX_W-1:0] index_after_reg;
    logic [1:0]         status_reg;

    always_ff @(posedge clk)
    begin
        if (ex_go)
        begin
            skip_reg        <= skip_c;
            vx_after_reg    <= vx_res;
            vf_after_reg    <= vf_res;
            index_after_reg <= idx_res;
            status_reg      <= st_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign skip        = skip_reg;
    assign vx_after    = vx_after_reg;
    assign vf_after    = vf_after_reg;
    assign index_after = index_after_reg;
    assign status      = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_skip_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        ex_go && (st_c != ST_DONE) |-> !skip_c)
        else $error("skip raised on a faulting request");

    a_fault_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        ex_go && (st_c != ST_DONE) |=> $stable(vf_reg) && $stable(idx_reg))
        else $error("state changed on a faulting request");

    a_state_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !ex_go |=> $stable(vf_reg) && $stable(idx_reg) && $stable(vld_reg))
        else $error("state changed without an executing request");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ex_go))
        else $error("result appeared without execution");

    a_exec_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ex_valid_reg) |-> $past(in_fire))
        else $error("execute stage filled without a request");

endmodule
